[hw/rtl/fwht_pkg.sv]
// ----------------------------------------------------------------------------
// fwht_pkg
// Shared types and constants of the Walsh-Hadamard transform block.
// ----------------------------------------------------------------------------
package fwht_pkg;

   localparam int LOG2_MAX_LEN_DEF = 10;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int CFG_BITS         = 4;
   localparam int LOG2_LEN_RESET   = 10;
   localparam int COEF_BITS        = 26;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_COEF     = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_READ   = 2'd1,
      CMD_REJECT = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       last;
   } cmd_ctl_type;

endpackage

[hw/rtl/fwht_ifs.sv]
// ----------------------------------------------------------------------------
// fwht channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwht_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output req_type, output sample_in, input ready);
   modport sink   (input valid, input req_type, input sample_in, output ready);
endinterface

interface fwht_rsp_if;
   import fwht_pkg::*;
   logic                        valid;
   logic                        ready;
   status_type                  status;
   logic signed [COEF_BITS-1:0] coef_out;
   logic                        last_coef;

   modport source (output valid, output status, output coef_out, output last_coef,
                   input ready);
   modport sink   (input valid, input status, input coef_out, input last_coef,
                   output ready);
endinterface

interface fwht_csr_if;
   import fwht_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] log2_length;

   modport source (output valid, output log2_length, input ready);
   modport sink   (input valid, input log2_length, output ready);
endinterface

[hw/rtl/fwht_ram.sv]
// ----------------------------------------------------------------------------
// fwht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fwht_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fwht_cmdq.sv]
// ----------------------------------------------------------------------------
// fwht_cmdq
// Two-entry command queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module fwht_cmdq #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'(DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[hw/rtl/fwht_front.sv]
// ----------------------------------------------------------------------------
// fwht_front
// Accepts requests, holds the frame bookkeeping and the length register,
// and turns each request into a push, read or reject command.
// ----------------------------------------------------------------------------
module fwht_front #(
   parameter int LOG2_MAX_LEN = 10,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   fwht_req_if.sink                              req,
   fwht_csr_if.sink                              csr,
   output logic                                  q_valid,
   input  logic                                  q_ready,
   output fwht_pkg::cmd_ctl_type                 q_ctl,
   output logic [LOG2_MAX_LEN-1:0]               q_addr,
   output logic signed [SAMPLE_BITS-1:0]         q_sample,
   output logic [$clog2(LOG2_MAX_LEN+1)-1:0]     lg
);
   import fwht_pkg::*;

   localparam int AW = LOG2_MAX_LEN;
   localparam int SW = $clog2(LOG2_MAX_LEN + 1);
   localparam int LG_RESET = (LOG2_LEN_RESET > LOG2_MAX_LEN) ? LOG2_MAX_LEN
                                                              : LOG2_LEN_RESET;

   logic [SW-1:0] lg_ff, lg_in;
   logic [AW-1:0] load_cnt_ff, load_cnt_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          pending_ff, pending_in;
   logic [AW-1:0] len_m1;
   logic          accept;
   logic          is_push;

   function automatic logic [SW-1:0] clamp_lg(input logic [CFG_BITS-1:0] v);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (int'(v) > LOG2_MAX_LEN) begin
         r = SW'(LOG2_MAX_LEN);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   assign len_m1   = AW'(((AW+1)'(1) << lg_ff) - (AW+1)'(1));
   assign req.ready = q_ready;
   assign csr.ready = 1'b1;
   assign accept   = req.valid && q_ready;
   assign is_push  = (req.req_type == 1'b0);
   assign q_valid  = req.valid;
   assign q_sample = req.sample_in;
   assign lg       = lg_ff;

   always_comb begin
      q_ctl.op   = CMD_REJECT;
      q_ctl.last = 1'b0;
      q_addr     = '0;
      if (is_push && !pending_ff) begin
         q_ctl.op   = CMD_PUSH;
         q_ctl.last = (load_cnt_ff == len_m1);
         q_addr     = load_cnt_ff;
      end else if (!is_push && pending_ff) begin
         q_ctl.op   = CMD_READ;
         q_ctl.last = (rd_idx_ff == len_m1);
         q_addr     = rd_idx_ff;
      end
   end

   always_comb begin
      lg_in       = lg_ff;
      load_cnt_in = load_cnt_ff;
      rd_idx_in   = rd_idx_ff;
      pending_in  = pending_ff;
      if (csr.valid) begin
         lg_in       = clamp_lg(csr.log2_length);
         load_cnt_in = '0;
         rd_idx_in   = '0;
         pending_in  = 1'b0;
      end else if (accept) begin
         unique case (q_ctl.op)
            CMD_PUSH: begin
               if (q_ctl.last) begin
                  load_cnt_in = '0;
                  rd_idx_in   = '0;
                  pending_in  = 1'b1;
               end else begin
                  load_cnt_in = load_cnt_ff + AW'(1);
               end
            end
            CMD_READ: begin
               if (q_ctl.last) begin
                  rd_idx_in  = '0;
                  pending_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff       <= SW'(LG_RESET);
         load_cnt_ff <= '0;
         rd_idx_ff   <= '0;
         pending_ff  <= 1'b0;
      end else begin
         lg_ff       <= lg_in;
         load_cnt_ff <= load_cnt_in;
         rd_idx_ff   <= rd_idx_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

[hw/rtl/fwht_back.sv]
// ----------------------------------------------------------------------------
// fwht_back
// Executes queued commands against the frame RAM, runs the butterfly
// passes after the last sample and drives the response register.
// ----------------------------------------------------------------------------
module fwht_back #(
   parameter int LOG2_MAX_LEN = 10,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  fwht_pkg::cmd_ctl_type             cmd_ctl,
   input  logic [LOG2_MAX_LEN-1:0]           cmd_addr,
   input  logic signed [SAMPLE_BITS-1:0]     cmd_sample,
   input  logic [$clog2(LOG2_MAX_LEN+1)-1:0] lg,
   fwht_rsp_if.source                        rsp
);
   import fwht_pkg::*;

   localparam int AW = LOG2_MAX_LEN;
   localparam int SW = $clog2(LOG2_MAX_LEN + 1);
   localparam int DW = SAMPLE_BITS + LOG2_MAX_LEN;
   localparam int XW = (DW > COEF_BITS) ? DW : COEF_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_RD_A,
      S_RD_B,
      S_WR_SUM,
      S_WR_DIFF
   } state_type;

   state_type                   state_ff, state_in;
   logic [SW-1:0]               stg_ff, stg_in;
   logic [AW-1:0]               k_ff, k_in;
   logic [DW-1:0]               a_ff, a_in;
   logic [DW-1:0]               b_ff, b_in;
   logic                        pend_last_ff, pend_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  status_ff, status_in;
   logic signed [COEF_BITS-1:0] coef_ff, coef_in;
   logic                        last_ff, last_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [DW-1:0]               wr_data, rd_data;
   logic [AW-1:0]               span, lo_mask, ia, ib, half_m1;
   logic signed [XW-1:0]        coef_ext;
   logic                        rsp_free;

   fwht_ram #(
      .WIDTH (DW),
      .DEPTH (1 << LOG2_MAX_LEN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // butterfly pair: insert a zero at the span bit of the pair counter
   assign span     = AW'(1) << stg_ff;
   assign lo_mask  = span - AW'(1);
   assign ia       = ((k_ff & ~lo_mask) << 1) | (k_ff & lo_mask);
   assign ib       = ia | span;
   assign half_m1  = AW'((((AW+1)'(1) << lg) >> 1) - (AW+1)'(1));
   assign coef_ext = XW'(signed'(rd_data));
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.coef_out  = coef_ff;
   assign rsp.last_coef = last_ff;

   always_comb begin
      state_in     = state_ff;
      stg_in       = stg_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      coef_in      = coef_ff;
      last_in      = last_ff;
      cmd_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = rsp_free;
            if (cmd_valid && rsp_free) begin
               unique case (cmd_ctl.op)
                  CMD_PUSH: begin
                     wr_en        = 1'b1;
                     wr_addr      = cmd_addr;
                     wr_data      = DW'(cmd_sample);
                     rsp_valid_in = 1'b1;
                     status_in    = ST_ACCEPTED;
                     coef_in      = '0;
                     last_in      = 1'b0;
                     if (cmd_ctl.last) begin
                        stg_in   = '0;
                        k_in     = '0;
                        state_in = S_RD_A;
                     end
                  end
                  CMD_READ: begin
                     rd_addr      = cmd_addr;
                     pend_last_in = cmd_ctl.last;
                     state_in     = S_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_REJECTED;
                     coef_in      = '0;
                     last_in      = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            status_in    = ST_COEF;
            coef_in      = coef_ext[COEF_BITS-1:0];
            last_in      = pend_last_ff;
            state_in     = S_IDLE;
         end
         S_RD_A: begin
            rd_addr  = ia;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            rd_addr  = ib;
            a_in     = rd_data;
            state_in = S_WR_SUM;
         end
         S_WR_SUM: begin
            wr_en    = 1'b1;
            wr_addr  = ia;
            wr_data  = a_ff + rd_data;
            b_in     = rd_data;
            state_in = S_WR_DIFF;
         end
         S_WR_DIFF: begin
            wr_en   = 1'b1;
            wr_addr = ib;
            wr_data = a_ff - b_ff;
            if (k_ff == half_m1) begin
               k_in = '0;
               if (stg_ff == lg - SW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  stg_in   = stg_ff + SW'(1);
                  state_in = S_RD_A;
               end
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_RD_A;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stg_ff       <= stg_in;
      k_ff         <= k_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      pend_last_ff <= pend_last_in;
      status_ff    <= status_in;
      coef_ff      <= coef_in;
      last_ff      <= last_in;
   end

endmodule

[hw/rtl/fast_walsh_hadamard_transform.sv]
// a push or reject passes the command queue and the response register; a read also
//   passes the RAM read; one item per cycle enters the two-entry command queue while
//   it has room; every command waits for a free response register; a frame's last
//   push starts log2(len) butterfly passes, each butterfly stepping through S_RD_A,
//   S_RD_B, S_WR_SUM and S_WR_DIFF over the single-read-port frame RAM
// reset: bookkeeping and response cleared, length 10; frame RAM is not cleared
// ----------------------------------------------------------------------------
// fast_walsh_hadamard_transform
// Frame-based natural-order Walsh-Hadamard transform with push/read requests.
// ----------------------------------------------------------------------------
module fast_walsh_hadamard_transform #(
   parameter int LOG2_MAX_LEN = fwht_pkg::LOG2_MAX_LEN_DEF,
   parameter int SAMPLE_BITS  = fwht_pkg::SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fwht_req_if.sink   req_ch,
   fwht_rsp_if.source rsp_ch,
   fwht_csr_if.sink   csr_ch
);
   import fwht_pkg::*;

   localparam int AW = LOG2_MAX_LEN;
   localparam int SW = $clog2(LOG2_MAX_LEN + 1);
   localparam int CW = $bits(cmd_ctl_type);
   localparam int QW = CW + AW + SAMPLE_BITS;

   logic                          fq_valid, fq_ready;
   cmd_ctl_type                   fq_ctl;
   logic [AW-1:0]                 fq_addr;
   logic signed [SAMPLE_BITS-1:0] fq_sample;
   logic [SW-1:0]                 lg;
   logic                          qb_valid, qb_ready;
   logic [QW-1:0]                 qb_data;
   cmd_ctl_type                   qb_ctl;

   fwht_front #(
      .LOG2_MAX_LEN (LOG2_MAX_LEN),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .csr      (csr_ch),
      .q_valid  (fq_valid),
      .q_ready  (fq_ready),
      .q_ctl    (fq_ctl),
      .q_addr   (fq_addr),
      .q_sample (fq_sample),
      .lg       (lg)
   );

   fwht_cmdq #(
      .WIDTH (QW)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({fq_ctl, fq_addr, fq_sample}),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   assign qb_ctl = cmd_ctl_type'(qb_data[QW-1 -: CW]);

   fwht_back #(
      .LOG2_MAX_LEN (LOG2_MAX_LEN),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (qb_valid),
      .cmd_ready  (qb_ready),
      .cmd_ctl    (qb_ctl),
      .cmd_addr   (qb_data[SAMPLE_BITS +: AW]),
      .cmd_sample (qb_data[SAMPLE_BITS-1:0]),
      .lg         (lg),
      .rsp        (rsp_ch)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of fast_walsh_hadamard_transform
// Loads frames of samples at several transform lengths, reads the coefficients
// back and checks every response against a behavioral transform kept in the
// bench. Both handshake sides idle and stall at random, with one long stall.
// ----------------------------------------------------------------------------
module tb;
   import fwht_pkg::*;

   localparam int          MAX_LEN       = 1 << LOG2_MAX_LEN_DEF;
   localparam logic        REQ_PUSH      = 1'b0;
   localparam logic        REQ_READ      = 1'b1;
   localparam int          QUIET_LIMIT   = 100_000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          RANDOM_ITEMS  = 1350;
   localparam int          REPORT_LIMIT  = 10;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_type;

   typedef struct {
      logic       rd;
      sample_type smp;
   } req_item_type;

   typedef struct {
      status_type                  status;
      logic signed [COEF_BITS-1:0] coef;
      logic                        last;
   } coef_resp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fwht_req_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) req_if ();
   fwht_rsp_if                                  rsp_if ();
   fwht_csr_if                                  csr_if ();

   fast_walsh_hadamard_transform u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // transform state mirrored in the bench
   longint                frame_mem [MAX_LEN];
   int unsigned           fill_count    = 0;
   int unsigned           out_index     = 0;
   bit                    coefs_pending = 1'b0;
   bit                    xform_fresh   = 1'b0;
   logic [CFG_BITS-1:0]   len_code      = CFG_BITS'(LOG2_LEN_RESET);

   req_item_type  req_pending_q [$];
   coef_resp_type resp_expect_q [$];

   bit          req_taken      = 1'b0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          hold_req       = 1'b0;
   bit          hold_ack       = 1'b0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;
   int          mismatches     = 0;
   int          reqs_accepted  = 0;
   int          coefs_checked  = 0;
   int          rejects_seen   = 0;
   int          cfg_writes     = 0;
   int          stim_count     = 0;
   bit          full_frame_done = 1'b0;
   bit [15:0]   codes_seen     = '0;

   function automatic int unsigned frame_size();
      int unsigned lg;
      lg = len_code;
      if (lg < 1) lg = 1;
      if (lg > LOG2_MAX_LEN_DEF) lg = LOG2_MAX_LEN_DEF;
      return 1 << lg;
   endfunction

   function automatic void run_butterflies(input int unsigned n);
      int unsigned span, base, k;
      longint      a, b;
      for (span = 1; span < n; span = span << 1) begin
         for (base = 0; base < n; base += 2 * span) begin
            for (k = base; k < base + span; k++) begin
               a = frame_mem[k];
               b = frame_mem[k + span];
               frame_mem[k]        = a + b;
               frame_mem[k + span] = a - b;
            end
         end
      end
   endfunction

   function automatic coef_resp_type fwht_predict(input logic rd, input sample_type smp);
      coef_resp_type res;
      int unsigned   n;
      longint        v;
      n = frame_size();
      res.status = ST_REJECTED;
      res.coef   = '0;
      res.last   = 1'b0;
      if (rd == REQ_PUSH) begin
         if (!coefs_pending) begin
            frame_mem[fill_count] = smp;
            fill_count++;
            res.status = ST_ACCEPTED;
            if (fill_count >= n) begin
               run_butterflies(n);
               fill_count    = 0;
               out_index     = 0;
               coefs_pending = 1'b1;
               xform_fresh   = 1'b1;
            end
         end
      end else if (coefs_pending) begin
         v = frame_mem[out_index];
         res.status  = ST_COEF;
         res.coef    = v[COEF_BITS-1:0];
         xform_fresh = 1'b0;
         if (out_index + 1 >= n) begin
            res.last      = 1'b1;
            out_index     = 0;
            coefs_pending = 1'b0;
         end else begin
            out_index++;
         end
      end
      return res;
   endfunction

   function automatic sample_type pick_sample();
      logic [31:0] r;
      r = $urandom;
      case (r[31:29])
         3'd0: return 16'sh7FFF;
         3'd1: return 16'sh8000;
         3'd2: return {{12{r[3]}}, r[3:0]};
         default: return r[15:0];
      endcase
   endfunction

   function automatic void add_push(input sample_type smp);
      req_item_type item;
      item.rd  = REQ_PUSH;
      item.smp = smp;
      req_pending_q.push_back(item);
      stim_count++;
   endfunction

   function automatic void add_read();
      req_item_type item;
      item.rd  = REQ_READ;
      item.smp = pick_sample();
      req_pending_q.push_back(item);
      stim_count++;
   endfunction

   // driver
   always @(negedge clock) begin
      req_item_type item;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.req_type  <= REQ_PUSH;
         req_if.sample_in <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = req_pending_q.pop_front();
            req_if.valid     <= 1'b1;
            req_if.req_type  <= item.rd;
            req_if.sample_in <= item.smp;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, armed by toggling hold_req
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_left <= HOLD_CYCLES;
         hold_ack  <= hold_req;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      coef_resp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            resp_expect_q.push_back(fwht_predict(req_if.req_type, req_if.sample_in));
            reqs_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (resp_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected response: status %0d coef %0d last %0d",
                           $time, rsp_if.status, rsp_if.coef_out, rsp_if.last_coef);
            end else begin
               want = resp_expect_q.pop_front();
               if (want.status == ST_COEF) coefs_checked++;
               if (want.status == ST_REJECTED) rejects_seen++;
               if (rsp_if.status !== want.status || rsp_if.coef_out !== want.coef ||
                   rsp_if.last_coef !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected status %0d coef %0d last %0d",
                              $time, want.status, want.coef, want.last);
                     $display("   got status %0d coef %0d last %0d",
                              rsp_if.status, rsp_if.coef_out, rsp_if.last_coef);
                  end
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (reset == 1'b0);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("fast_walsh_hadamard_transform regression: fail");
      $finish;
   end

   // wait for all items to be taken and answered; a freshly filled frame may
   // still be in its butterfly passes, so give it time before a length write
   task automatic settle();
      int unsigned n;
      while (req_pending_q.size() != 0 || req_if.valid) @(posedge clock);
      while (resp_expect_q.size() != 0) @(posedge clock);
      n = frame_size();
      if (xform_fresh) repeat (2 * n * $clog2(n) + 32) @(posedge clock);
      else repeat (8) @(posedge clock);
   endtask

   task automatic write_length(input logic [CFG_BITS-1:0] code);
      @(negedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.log2_length <= code;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      len_code      = code;
      fill_count    = 0;
      out_index     = 0;
      coefs_pending = 1'b0;
      xform_fresh   = 1'b0;
      cfg_writes++;
      codes_seen[code] = 1'b1;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic queue_phase(input int unsigned n);
      int unsigned frames, f, k, part;
      if (n == MAX_LEN && !full_frame_done) begin
         // one full-length frame, read back only in part before the next write
         full_frame_done = 1'b1;
         add_read();
         for (k = 0; k < n; k++) add_push(pick_sample());
         add_push(pick_sample());
         for (k = 0; k < 48; k++) add_read();
      end else if (n >= 512) begin
         part = $urandom_range(120, 8);
         for (k = 0; k < part; k++) begin
            if ($urandom_range(9) == 0) add_read();
            else add_push(pick_sample());
         end
      end else begin
         frames = $urandom_range((128 / n > 1) ? 128 / n : 1, 1);
         for (f = 0; f < frames; f++) begin
            if ($urandom_range(5) == 0) add_read();
            for (k = 0; k < n; k++) begin
               add_push(pick_sample());
               if ($urandom_range(15) == 0) add_read();
            end
            if ($urandom_range(4) == 0) add_push(pick_sample());
            for (k = 0; k < n; k++) begin
               add_read();
               if ($urandom_range(23) == 0) add_push(pick_sample());
            end
            if ($urandom_range(4) == 0) add_read();
         end
         // partial frame left behind for the next length write to drop
         if ($urandom_range(2) == 0) begin
            part = $urandom_range(n - 1, 1);
            for (k = 0; k < part; k++) add_push(pick_sample());
         end
      end
   endtask

   int          cfg_plan [12] = '{3, 5, 15, 1, 7, 0, 4, 11, 2, 8, 6, 10};
   int          phase;
   logic [3:0]  code;

   initial begin
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_PUSH;
      req_if.sample_in   = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.log2_length = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset length, read with nothing pending, partial frame dropped
      add_read();
      add_push(16'sh7FFF);
      settle();
      write_length(4'd1);
      add_push(16'sh7FFF);
      add_push(16'sh8000);
      add_push(16'sd5);
      add_read();
      add_read();
      add_read();
      settle();
      // code zero behaves as length two
      write_length(4'd0);
      add_push(16'sh8000);
      add_push(16'sh8000);
      add_read();
      add_read();
      add_push(16'sd1);
      settle();
      write_length(4'd2);
      repeat (4) add_push(16'sh7FFF);
      add_read();
      add_read();
      settle();

      stim_count = 0;
      phase      = 0;
      while (stim_count < RANDOM_ITEMS) begin
         if (phase < 12) code = 4'(cfg_plan[phase]);
         else if ($urandom_range(3) == 0) code = 4'($urandom_range(15, 9));
         else code = 4'($urandom_range(6, 0));
         settle();
         write_length(code);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if (phase == 0) hold_req = ~hold_req;
         queue_phase(frame_size());
         phase++;
      end
      settle();
      repeat (20) @(posedge clock);

      if (resp_expect_q.size() != 0) begin
         $display("%0d responses never arrived", resp_expect_q.size());
         mismatches += resp_expect_q.size();
      end
      $display("checked %0d requests: %0d coefficients, %0d rejections, %0d mismatches",
               reqs_accepted, coefs_checked, rejects_seen, mismatches);
      $display("%0d length writes over %0d phases, %0d distinct length codes",
               cfg_writes, phase, $countones(codes_seen));
      if (mismatches == 0) begin
         $display("fast_walsh_hadamard_transform regression: pass");
      end else begin
         $display("fast_walsh_hadamard_transform regression: fail");
      end
      $finish;
   end

endmodule
